// ----- hdl/csq_pkg.sv -----
// Shared types and constants for the counting semaphore with wait queue.
`default_nettype none

package csq_pkg;

   localparam int COUNT_W  = 16;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 3;
   localparam int CFG_W    = 8;

   localparam logic signed [COUNT_W-1:0] COUNT_MAX  = 16'sh7FFF;
   localparam logic signed [COUNT_W-1:0] COUNT_ONE  = 16'sd1;
   localparam logic signed [COUNT_W-1:0] COUNT_ZERO = 16'sd0;

   typedef enum logic [MODE_W-1:0] {
      MODE_WAIT       = 3'd0,
      MODE_SIGNAL     = 3'd1,
      MODE_CLOSE      = 3'd2,
      MODE_TIMED_WAIT = 3'd3,
      MODE_TIMEOUT    = 3'd4,
      MODE_TRY_WAIT   = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_BLOCKED     = 3'd1,
      ST_CLOSED      = 3'd2,
      ST_WOULD_BLOCK = 3'd3,
      ST_TIMED_OUT   = 3'd4,
      ST_FULL        = 3'd5
   } status_type;

   typedef struct packed {
      logic       capture;
      logic       rd_en;
      logic       rd_ahead;
      logic       enqueue;
      logic       shift_wr;
      logic       idx_inc;
      logic       cnt_dec;
      logic       cnt_inc;
      logic       pop_head;
      logic       drop_tail;
      logic       set_closed;
      logic       clear_queue;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_woken;
      logic       rsp_by_close;
      logic       rsp_last;
   } cmd_type;

   typedef struct packed {
      logic     mode_ok;
      mode_type mode;
      logic     closed;
      logic     count_pos;
      logic     inc_le0;
      logic     empty;
      logic     full;
      logic     match;
      logic     idx_last;
   } stat_type;

endpackage

`default_nettype wire

// ----- hdl/csq_req_if.sv -----
// Request channel interface: valid, ready, mode and thread identifier.
`default_nettype none

interface csq_req_if #(parameter int THREAD_ID_BITS = 8);
   logic                         valid;
   logic                         ready;
   logic [csq_pkg::MODE_W-1:0]   mode;
   logic [THREAD_ID_BITS-1:0]    thread_id;

   modport source (output valid, output mode, output thread_id, input ready);
   modport sink   (input valid, input mode, input thread_id, output ready);
endinterface

`default_nettype wire

// ----- hdl/csq_rsp_if.sv -----
// Response channel interface: valid, ready and the result fields.
`default_nettype none

interface csq_rsp_if #(parameter int THREAD_ID_BITS = 8);
   logic                         valid;
   logic                         ready;
   logic [csq_pkg::STATUS_W-1:0] status;
   logic                         woken_valid;
   logic [THREAD_ID_BITS-1:0]    woken_thread;
   logic                         woken_by_close;
   logic                         last;

   modport source (output valid, output status, output woken_valid, output woken_thread,
                   output woken_by_close, output last, input ready);
   modport sink   (input valid, input status, input woken_valid, input woken_thread,
                   input woken_by_close, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/csq_dp.sv -----
// Datapath: count, closed flag, circular waiter queue memory and response registers.
`default_nettype none

module csq_dp #(
   parameter int QUEUE_DEPTH    = 16,
   parameter int THREAD_ID_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [csq_pkg::CFG_W-1:0]     csr_write_data,
   input  logic [csq_pkg::MODE_W-1:0]    req_mode,
   input  logic [THREAD_ID_BITS-1:0]     req_thread_id,
   input  csq_pkg::cmd_type              cmd,
   output csq_pkg::stat_type             stat,
   output logic [csq_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_woken_valid,
   output logic [THREAD_ID_BITS-1:0]     rsp_woken_thread,
   output logic                          rsp_woken_by_close,
   output logic                          rsp_last
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = PTR_W + 1;

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [SUM_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + off;
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   logic [THREAD_ID_BITS-1:0] mem [QUEUE_DEPTH];

   logic signed [csq_pkg::COUNT_W-1:0] count_ff, count_in, count_sat;
   logic                               closed_ff, closed_in;
   logic [PTR_W-1:0]                   head_ff, head_in;
   logic [PTR_W-1:0]                   tail_ff, tail_in;
   logic [CNT_W-1:0]                   total_ff, total_in;
   logic [PTR_W-1:0]                   idx_ff;
   logic [csq_pkg::MODE_W-1:0]         mode_ff;
   logic [THREAD_ID_BITS-1:0]          tid_ff;
   logic [THREAD_ID_BITS-1:0]          rd_data_ff;
   csq_pkg::status_type                status_ff;
   logic                               woken_valid_ff;
   logic [THREAD_ID_BITS-1:0]          woken_thread_ff;
   logic                               by_close_ff;
   logic                               last_ff;

   logic [PTR_W-1:0]          cur_addr, next_addr, rd_addr, wr_addr;
   logic [THREAD_ID_BITS-1:0] wr_data;
   logic                      wr_en;

   assign cur_addr  = wrap_add(head_ff, SUM_W'(idx_ff));
   assign next_addr = wrap_add(head_ff, SUM_W'(idx_ff) + SUM_W'(1));
   assign rd_addr   = cmd.rd_ahead ? next_addr : cur_addr;
   assign wr_en     = cmd.enqueue || cmd.shift_wr;
   assign wr_addr   = cmd.enqueue ? tail_ff : cur_addr;
   assign wr_data   = cmd.enqueue ? tid_ff : rd_data_ff;

   assign count_sat = (count_ff == csq_pkg::COUNT_MAX) ? count_ff
                                                       : count_ff + csq_pkg::COUNT_ONE;

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_dec) begin
         count_in = count_ff - csq_pkg::COUNT_ONE;
      end else if (cmd.cnt_inc) begin
         count_in = count_sat;
      end

      closed_in = closed_ff || cmd.set_closed;

      head_in = head_ff;
      tail_in = tail_ff;
      total_in = total_ff;
      if (cmd.clear_queue) begin
         head_in = '0;
         tail_in = '0;
         total_in = '0;
      end else if (cmd.enqueue) begin
         tail_in = wrap_add(tail_ff, SUM_W'(1));
         total_in = total_ff + CNT_W'(1);
      end else if (cmd.pop_head) begin
         head_in = wrap_add(head_ff, SUM_W'(1));
         total_in = total_ff - CNT_W'(1);
      end else if (cmd.drop_tail) begin
         tail_in = (tail_ff == '0) ? PTR_W'(QUEUE_DEPTH - 1) : tail_ff - PTR_W'(1);
         total_in = total_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= csq_pkg::COUNT_ZERO;
         closed_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
         total_ff <= '0;
      end else if (csr_write_enable) begin
         count_ff <= {{(csq_pkg::COUNT_W - csq_pkg::CFG_W){1'b0}}, csr_write_data};
         closed_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
         total_ff <= '0;
      end else begin
         count_ff <= count_in;
         closed_ff <= closed_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         tid_ff <= req_thread_id;
      end
      if (cmd.capture) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc || cmd.shift_wr) begin
         idx_ff <= idx_ff + PTR_W'(1);
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rsp_load) begin
         status_ff <= cmd.rsp_status;
         woken_valid_ff <= cmd.rsp_woken;
         woken_thread_ff <= cmd.rsp_woken ? rd_data_ff : '0;
         by_close_ff <= cmd.rsp_by_close;
         last_ff <= cmd.rsp_last;
      end
   end

   always_comb begin
      stat.mode_ok = mode_ff inside {[csq_pkg::MODE_WAIT : csq_pkg::MODE_TRY_WAIT]};
      stat.mode = csq_pkg::mode_type'(mode_ff);
      stat.closed = closed_ff;
      stat.count_pos = count_ff > csq_pkg::COUNT_ZERO;
      stat.inc_le0 = count_sat <= csq_pkg::COUNT_ZERO;
      stat.empty = total_ff == '0;
      stat.full = total_ff == CNT_W'(QUEUE_DEPTH);
      stat.match = rd_data_ff == tid_ff;
      stat.idx_last = (CNT_W'(idx_ff) + CNT_W'(1)) == total_ff;
   end

   assign rsp_status = status_ff;
   assign rsp_woken_valid = woken_valid_ff;
   assign rsp_woken_thread = woken_thread_ff;
   assign rsp_woken_by_close = by_close_ff;
   assign rsp_last = last_ff;

endmodule

`default_nettype wire

// ----- hdl/csq_ctrl.sv -----
// Controller: state machine that sequences each request and the response handshake.
`default_nettype none

module csq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   input  csq_pkg::stat_type     stat,
   output csq_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_WAKE,
      S_CLOSE,
      S_SCAN,
      S_SHIFT,
      S_SHIFT_WR
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rsp_status = csq_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!stat.mode_ok || stat.closed) begin
               if (slot_free) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_last = 1'b1;
                  cmd.rsp_status = stat.mode_ok ? csq_pkg::ST_CLOSED : csq_pkg::ST_OK;
                  state_in = S_IDLE;
               end
            end else begin
               case (stat.mode)
                  csq_pkg::MODE_WAIT, csq_pkg::MODE_TIMED_WAIT: begin
                     if (slot_free) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_last = 1'b1;
                        state_in = S_IDLE;
                        if (stat.count_pos) begin
                           cmd.cnt_dec = 1'b1;
                        end else if (stat.full) begin
                           cmd.rsp_status = csq_pkg::ST_FULL;
                        end else begin
                           cmd.cnt_dec = 1'b1;
                           cmd.enqueue = 1'b1;
                           cmd.rsp_status = csq_pkg::ST_BLOCKED;
                        end
                     end
                  end
                  csq_pkg::MODE_TRY_WAIT: begin
                     if (slot_free) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_last = 1'b1;
                        state_in = S_IDLE;
                        if (stat.count_pos) begin
                           cmd.cnt_dec = 1'b1;
                        end else begin
                           cmd.rsp_status = csq_pkg::ST_WOULD_BLOCK;
                        end
                     end
                  end
                  csq_pkg::MODE_SIGNAL: begin
                     if (stat.inc_le0 && !stat.empty) begin
                        cmd.rd_en = 1'b1;
                        state_in = S_WAKE;
                     end else if (slot_free) begin
                        cmd.cnt_inc = 1'b1;
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_last = 1'b1;
                        state_in = S_IDLE;
                     end
                  end
                  csq_pkg::MODE_CLOSE: begin
                     if (!stat.empty) begin
                        cmd.rd_en = 1'b1;
                        state_in = S_CLOSE;
                     end else if (slot_free) begin
                        cmd.set_closed = 1'b1;
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_last = 1'b1;
                        state_in = S_IDLE;
                     end
                  end
                  csq_pkg::MODE_TIMEOUT: begin
                     if (!stat.empty) begin
                        cmd.rd_en = 1'b1;
                        state_in = S_SCAN;
                     end else if (slot_free) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_last = 1'b1;
                        state_in = S_IDLE;
                     end
                  end
                  default: begin
                     if (slot_free) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_last = 1'b1;
                        state_in = S_IDLE;
                     end
                  end
               endcase
            end
         end
         S_WAKE: begin
            if (slot_free) begin
               cmd.cnt_inc = 1'b1;
               cmd.pop_head = 1'b1;
               cmd.rsp_load = 1'b1;
               cmd.rsp_woken = 1'b1;
               cmd.rsp_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CLOSE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_woken = 1'b1;
               cmd.rsp_by_close = 1'b1;
               cmd.rsp_last = stat.idx_last;
               if (stat.idx_last) begin
                  cmd.set_closed = 1'b1;
                  cmd.clear_queue = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  cmd.rd_en = 1'b1;
                  cmd.rd_ahead = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (stat.match) begin
               state_in = S_SHIFT;
            end else if (stat.idx_last) begin
               if (slot_free) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_last = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               cmd.rd_en = 1'b1;
               cmd.rd_ahead = 1'b1;
            end
         end
         S_SHIFT: begin
            if (stat.idx_last) begin
               if (slot_free) begin
                  cmd.drop_tail = 1'b1;
                  cmd.cnt_inc = 1'b1;
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_last = 1'b1;
                  cmd.rsp_status = csq_pkg::ST_TIMED_OUT;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.rd_en = 1'b1;
               cmd.rd_ahead = 1'b1;
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in = S_SHIFT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/counting_semaphore_wait_queue.sv -----
// Top level of the counting semaphore with a FIFO wait queue.
// A request passes through capture and dispatch to a registered result; a signal that wakes a
// waiter adds a read of the queue head, a close that releases N waiters gives one result per
// waiter, and a timeout searches the queue entry by entry and then shifts the later entries down.
// One request is processed at a time; a new request is taken only when the controller is idle.
// Reset is synchronous: count 0, semaphore open, queue empty; no clearing pass is needed.
`default_nettype none

module counting_semaphore_wait_queue #(
   parameter int QUEUE_DEPTH    = 16,
   parameter int THREAD_ID_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [csq_pkg::CFG_W-1:0] csr_write_data,
   csq_req_if.sink                   req_chan,
   csq_rsp_if.source                 rsp_chan
);

   csq_pkg::cmd_type  cmd;
   csq_pkg::stat_type stat;

   csq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   csq_dp #(
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .THREAD_ID_BITS (THREAD_ID_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_mode           (req_chan.mode),
      .req_thread_id      (req_chan.thread_id),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_status         (rsp_chan.status),
      .rsp_woken_valid    (rsp_chan.woken_valid),
      .rsp_woken_thread   (rsp_chan.woken_thread),
      .rsp_woken_by_close (rsp_chan.woken_by_close),
      .rsp_last           (rsp_chan.last)
   );

   a_one_request_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("Request accepted while a previous transaction was still in progress.");

   a_close_sets_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.woken_by_close && rsp_chan.last |-> stat.closed)
      else $error("Final close release delivered without the closed flag set.");

   a_closed_with_last: assert property (@(posedge clock) disable iff (reset)
      $rose(stat.closed) |-> rsp_chan.valid && rsp_chan.last)
      else $error("Closed flag rose without a final result pending.");

endmodule

`default_nettype wire
